@@ src/mwe_pkg.sv @@
// ----------------------------------------------------------------------------
// mwe_pkg
// Types and constants shared by the multi-well Euler filter modules.
// ----------------------------------------------------------------------------
package mwe_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int FRAC_BITS    = 16;
  localparam int WCNT_W       = 5;
  localparam int XB_W         = 23;
  localparam int GAIN_W       = 16;
  localparam int IDX_W        = 4;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  // Internal datapath widths
  localparam int CENTRE_W = 32;  // well centres and offsets from a centre
  localparam int MUL_W    = 34;  // shared multiplier operand width
  localparam int PROD_W   = 64;  // kept product width
  localparam int Q_W      = 33;  // clipped square, range [-2^31, 2^31]
  localparam int CUBE_W   = 41;  // clipped cube, range [-2^39, 2^39]
  localparam int SPLIT    = 20;  // cube split point for the two partial products
  localparam int SUM_W    = SAMPLE_WIDTH + 2;

  localparam logic signed [PROD_W-1:0] Q_LIMIT    = 64'sd2147483648;
  localparam logic signed [PROD_W-1:0] CUBE_LIMIT = 64'sd549755813888;
  localparam logic signed [PROD_W-1:0] V_MAX =
    (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [PROD_W-1:0] V_MIN = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

  // Register map indexes
  localparam logic [1:0] REG_STEP_GAIN    = 2'd0;
  localparam logic [1:0] REG_WELL_COUNT   = 2'd1;
  localparam logic [1:0] REG_HALF_SPACING = 2'd2;
  localparam logic [1:0] REG_INV_SPACING  = 2'd3;

  localparam logic [GAIN_W-1:0] RST_STEP_GAIN    = 16'd655;
  localparam logic [WCNT_W-1:0] RST_WELL_COUNT   = 5'd2;
  localparam logic [XB_W-1:0]   RST_HALF_SPACING = 23'd65536;
  localparam logic [XB_W-1:0]   RST_INV_SPACING  = 23'd65536;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] signal_sample;
    logic signed [SAMPLE_WIDTH-1:0] noise_sample;
  } mwe_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] filtered_state;
    logic [IDX_W-1:0]               well_index;
    logic                           saturated;
  } mwe_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] step_gain;
    logic [WCNT_W-1:0] well_count;
    logic [XB_W-1:0]   well_half_spacing;
    logic [XB_W-1:0]   inv_half_spacing_sq;
  } mwe_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CINIT,
    ST_CSET,
    ST_SCAN,
    ST_MUL_DD,
    ST_CLIP_Q,
    ST_MUL_QD,
    ST_CLIP_C,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_ACC,
    ST_GRAD,
    ST_SUM,
    ST_MUL_G,
    ST_NEXT
  } mwe_state_e;

  typedef enum logic [2:0] {
    MUL_CENTRE,
    MUL_DD,
    MUL_QD,
    MUL_HI,
    MUL_LO,
    MUL_GAIN
  } mwe_mul_e;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mwe_mul_e mul_sel;
    logic     centre_init;
    logic     scan;
    logic     load_q;
    logic     load_cube;
    logic     load_acc;
    logic     add_acc;
    logic     load_grad;
    logic     load_sum;
    logic     commit;
  } mwe_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } mwe_stat_t;

endpackage

@@ src/mwe_regs.sv @@
// ----------------------------------------------------------------------------
// mwe_regs
// APB-style configuration registers of the multi-well Euler filter.
// ----------------------------------------------------------------------------
module mwe_regs import mwe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output mwe_cfg_t          cfg_o
);

  mwe_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_gain           <= RST_STEP_GAIN;
      cfg_q.well_count          <= RST_WELL_COUNT;
      cfg_q.well_half_spacing   <= RST_HALF_SPACING;
      cfg_q.inv_half_spacing_sq <= RST_INV_SPACING;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STEP_GAIN:    cfg_q.step_gain           <= pwdata[GAIN_W-1:0];
        REG_WELL_COUNT:   cfg_q.well_count          <= pwdata[WCNT_W-1:0];
        REG_HALF_SPACING: cfg_q.well_half_spacing   <= pwdata[XB_W-1:0];
        REG_INV_SPACING:  cfg_q.inv_half_spacing_sq <= pwdata[XB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STEP_GAIN:    prdata = DATA_W'(cfg_q.step_gain);
      REG_WELL_COUNT:   prdata = DATA_W'(cfg_q.well_count);
      REG_HALF_SPACING: prdata = DATA_W'(cfg_q.well_half_spacing);
      REG_INV_SPACING:  prdata = DATA_W'(cfg_q.inv_half_spacing_sq);
      default:          prdata = '0;
    endcase
  end

endmodule

@@ src/mwe_ctrl.sv @@
// ----------------------------------------------------------------------------
// mwe_ctrl
// Sequencer for one filter step: well scan, gradient chain, state update.
// ----------------------------------------------------------------------------
module mwe_ctrl import mwe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  mwe_stat_t stat_i,
  output mwe_cmd_t  cmd_o
);

  mwe_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CINIT;
        end
      end
      ST_CINIT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_CENTRE;
        state_d       = ST_CSET;
      end
      ST_CSET: begin
        cmd_o.centre_init = 1'b1;
        state_d           = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          state_d = ST_MUL_DD;
        end else if (stat_i.last) begin
          // no well held the state: gradient is zero
          state_d = ST_SUM;
        end
      end
      ST_MUL_DD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DD;
        state_d       = ST_CLIP_Q;
      end
      ST_CLIP_Q: begin
        cmd_o.load_q = 1'b1;
        state_d      = ST_MUL_QD;
      end
      ST_MUL_QD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_QD;
        state_d       = ST_CLIP_C;
      end
      ST_CLIP_C: begin
        cmd_o.load_cube = 1'b1;
        state_d         = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HI;
        state_d       = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_LO;
        cmd_o.load_acc = 1'b1;
        state_d        = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.add_acc = 1'b1;
        state_d       = ST_GRAD;
      end
      ST_GRAD: begin
        cmd_o.load_grad = 1'b1;
        state_d         = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.load_sum = 1'b1;
        state_d        = ST_MUL_G;
      end
      ST_MUL_G: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GAIN;
        state_d       = ST_NEXT;
      end
      ST_NEXT: begin
        // hold until the output register can take the item
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.commit | (out_valid_q & out_stall_i);

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || !out_stall_i))
    else $error("commit while output item still held");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_CINIT))
    else $error("accepted item did not start the centre setup");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.commit))
    else $error("output valid rose without a commit");

endmodule

@@ src/mwe_dp.sv @@
// ----------------------------------------------------------------------------
// mwe_dp
// Datapath: well scan, shared multiplier, clipping and the filter state.
// ----------------------------------------------------------------------------
module mwe_dp import mwe_pkg::*; #(
  parameter int MAX_WELLS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mwe_cfg_t  cfg_i,
  input  mwe_in_t   in_data_i,
  input  mwe_cmd_t  cmd_i,
  output mwe_stat_t stat_o,
  output mwe_out_t  out_data_o
);

  logic signed [SAMPLE_WIDTH-1:0] s_q, n_q, x_q, g_q;
  logic signed [CENTRE_W-1:0]     c_q, d_q;
  logic [WCNT_W-1:0]              cnt_q;
  logic [IDX_W-1:0]               idx_q;
  logic signed [Q_W-1:0]          q_q;
  logic signed [CUBE_W-1:0]       cube_q;
  logic signed [PROD_W-1:0]       p_q, acc_q;
  logic signed [SUM_W-1:0]        sum_q;
  logic                           sat_q;
  mwe_out_t                       out_q;

  logic [WCNT_W-1:0]          nw_eff, nw_m1;
  logic signed [CENTRE_W-1:0] xb_ext, x_ext, lo, hi;
  logic                       first_w, last_w, hit;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [2*MUL_W-1:0]  prod;
  logic signed [PROD_W-1:0]   p_sh, t_sh, g_raw, nx_raw;
  logic signed [Q_W-1:0]      q_clip;
  logic signed [CUBE_W-1:0]   cube_clip;
  logic signed [SAMPLE_WIDTH-1:0] g_clip, nx_clip;
  logic                       q_sat, c_sat, g_sat, nx_sat;

  // Clamp the well count into 1..MAX_WELLS
  always_comb begin
    if (cfg_i.well_count == '0) begin
      nw_eff = WCNT_W'(1);
    end else if (int'(cfg_i.well_count) > MAX_WELLS) begin
      nw_eff = WCNT_W'(MAX_WELLS);
    end else begin
      nw_eff = cfg_i.well_count;
    end
  end
  assign nw_m1 = nw_eff - WCNT_W'(1);

  // Well test for the current scan position
  assign xb_ext  = CENTRE_W'(cfg_i.well_half_spacing);
  assign x_ext   = CENTRE_W'(x_q);
  assign lo      = c_q - xb_ext;
  assign hi      = c_q + xb_ext;
  assign first_w = (cnt_q == '0);
  assign last_w  = (cnt_q == nw_m1);
  assign hit     = (first_w && (x_ext <= hi)) || (last_w && (x_ext >= lo)) ||
                   (!first_w && !last_w && (x_ext >= lo) && (x_ext <= hi));

  assign stat_o.hit  = hit;
  assign stat_o.last = last_w;

  // Shared multiplier, one product per cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_CENTRE: begin
        mul_a = {{(MUL_W-WCNT_W){1'b0}}, nw_m1};
        mul_b = {{(MUL_W-XB_W){1'b0}}, cfg_i.well_half_spacing};
      end
      MUL_DD: begin
        mul_a = MUL_W'(d_q);
        mul_b = MUL_W'(d_q);
      end
      MUL_QD: begin
        mul_a = MUL_W'(q_q);
        mul_b = MUL_W'(d_q);
      end
      MUL_HI: begin
        mul_a = MUL_W'($signed(cube_q[CUBE_W-1:SPLIT]));
        mul_b = {{(MUL_W-XB_W){1'b0}}, cfg_i.inv_half_spacing_sq};
      end
      MUL_LO: begin
        mul_a = {{(MUL_W-SPLIT){1'b0}}, cube_q[SPLIT-1:0]};
        mul_b = {{(MUL_W-XB_W){1'b0}}, cfg_i.inv_half_spacing_sq};
      end
      MUL_GAIN: begin
        mul_a = MUL_W'(sum_q);
        mul_b = {{(MUL_W-GAIN_W){1'b0}}, cfg_i.step_gain};
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  // Floor shifts and clipping
  always_comb begin
    p_sh  = p_q >>> FRAC_BITS;
    q_sat = 1'b0;
    c_sat = 1'b0;
    g_sat = 1'b0;
    nx_sat = 1'b0;

    if (p_sh > Q_LIMIT) begin
      q_clip = Q_W'(Q_LIMIT);
      q_sat  = 1'b1;
    end else if (p_sh < -Q_LIMIT) begin
      q_clip = Q_W'(-Q_LIMIT);
      q_sat  = 1'b1;
    end else begin
      q_clip = Q_W'(p_sh);
    end

    if (p_sh > CUBE_LIMIT) begin
      cube_clip = CUBE_W'(CUBE_LIMIT);
      c_sat     = 1'b1;
    end else if (p_sh < -CUBE_LIMIT) begin
      cube_clip = CUBE_W'(-CUBE_LIMIT);
      c_sat     = 1'b1;
    end else begin
      cube_clip = CUBE_W'(p_sh);
    end

    t_sh  = acc_q >>> FRAC_BITS;
    g_raw = t_sh - PROD_W'(d_q);
    if (g_raw > V_MAX) begin
      g_clip = SAMPLE_WIDTH'(V_MAX);
      g_sat  = 1'b1;
    end else if (g_raw < V_MIN) begin
      g_clip = SAMPLE_WIDTH'(V_MIN);
      g_sat  = 1'b1;
    end else begin
      g_clip = SAMPLE_WIDTH'(g_raw);
    end

    nx_raw = PROD_W'(x_q) + p_sh;
    if (nx_raw > V_MAX) begin
      nx_clip = SAMPLE_WIDTH'(V_MAX);
      nx_sat  = 1'b1;
    end else if (nx_raw < V_MIN) begin
      nx_clip = SAMPLE_WIDTH'(V_MIN);
      nx_sat  = 1'b1;
    end else begin
      nx_clip = SAMPLE_WIDTH'(nx_raw);
    end
  end

  // Filter state and scan counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.centre_init) begin
        cnt_q <= '0;
      end else if (cmd_i.scan && !hit && !last_w) begin
        cnt_q <= cnt_q + WCNT_W'(1);
      end
      if (cmd_i.commit) begin
        x_q <= nx_clip;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      s_q <= in_data_i.signal_sample;
      n_q <= in_data_i.noise_sample;
    end
    if (cmd_i.mul_en) begin
      p_q <= prod[PROD_W-1:0];
    end
    if (cmd_i.centre_init) begin
      c_q <= CENTRE_W'(-p_q);
    end else if (cmd_i.scan && !hit && !last_w) begin
      c_q <= c_q + (xb_ext <<< 1);
    end
    if (cmd_i.scan) begin
      if (hit) begin
        d_q   <= x_ext - c_q;
        idx_q <= cnt_q[IDX_W-1:0];
      end else if (last_w) begin
        g_q   <= '0;
        idx_q <= '0;
      end
    end
    if (cmd_i.load_q) begin
      q_q <= q_clip;
    end
    if (cmd_i.load_cube) begin
      cube_q <= cube_clip;
    end
    if (cmd_i.load_acc) begin
      acc_q <= p_q <<< SPLIT;
    end else if (cmd_i.add_acc) begin
      acc_q <= acc_q + p_q;
    end
    if (cmd_i.load_grad) begin
      g_q <= g_clip;
    end
    if (cmd_i.load_sum) begin
      sum_q <= SUM_W'(s_q) + SUM_W'(n_q) - SUM_W'(g_q);
    end
    if (cmd_i.load_in) begin
      sat_q <= 1'b0;
    end else if ((cmd_i.load_q && q_sat) || (cmd_i.load_cube && c_sat) ||
                 (cmd_i.load_grad && g_sat)) begin
      sat_q <= 1'b1;
    end
    if (cmd_i.commit) begin
      out_q.filtered_state <= nx_clip;
      out_q.well_index     <= idx_q;
      out_q.saturated      <= sat_q | nx_sat;
    end
  end

  assign out_data_o = out_q;

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (cnt_q <= nw_m1))
    else $error("well scan ran past the last well");

  a_square_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_cube |-> !q_q[Q_W-1])
    else $error("clipped square is negative");

  a_sat_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_in |=> !sat_q)
    else $error("saturation flag not cleared for a new item");

endmodule

@@ src/multi_well_euler_filter.sv @@
// ----------------------------------------------------------------------------
// multi_well_euler_filter
// Output valid rises once the well scan, gradient chain and state update
// are done; the scan tests one well per cycle. The input stalls until the
// step is committed, so a new item is taken only after the previous one;
// one shared multiplier carries up to six products of a step. Reset clears
// the filter state to zero and loads the register defaults.
// ----------------------------------------------------------------------------
module multi_well_euler_filter import mwe_pkg::*; #(
  parameter int MAX_WELLS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mwe_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mwe_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  mwe_cfg_t  cfg;
  mwe_cmd_t  cmd;
  mwe_stat_t stat;

  mwe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mwe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mwe_dp #(
    .MAX_WELLS (MAX_WELLS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-well Euler filter. Sample pairs are queued
// and driven over the valid/stall input channel. A predictor follows the
// filter state, the well scan and the clipping for every item the block takes.
// Results are checked field by field in order. Register settings change
// through the APB port between phases, while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mwe_pkg::*;

  localparam int     CLK_HALF        = 4;
  localparam int     RESET_CYCLES    = 5;
  localparam int     WATCHDOG_LIMIT  = 5000;
  localparam int     DRAIN_CYCLES    = 40;
  localparam int     RANDOM_PHASES   = 9;
  localparam int     ITEMS_PER_PHASE = 78;
  localparam int     MAX_WELLS       = 16;
  localparam longint STATE_MAX       = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam longint STATE_MIN       = -(64'sd1 <<< (SAMPLE_WIDTH - 1));
  localparam longint SQ_LIMIT        = 64'sd1 <<< 31;
  localparam longint CUBE_LIMIT_TB   = 64'sd1 <<< 39;
  localparam longint XB_FULL         = (64'sd1 <<< XB_W) - 64'sd1;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  mwe_in_t           in_data   = '0;
  logic              out_stall = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic              in_stall;
  logic              out_valid;
  mwe_out_t          out_data;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // register copies and filter state as the block should hold them
  logic [GAIN_W-1:0] gain_sh    = RST_STEP_GAIN;
  logic [WCNT_W-1:0] wells_sh   = RST_WELL_COUNT;
  logic [XB_W-1:0]   spacing_sh = RST_HALF_SPACING;
  logic [XB_W-1:0]   inv_sh     = RST_INV_SPACING;
  longint            state_sh   = 0;

  mwe_in_t  pending_items[$];
  mwe_out_t expected_results[$];
  int       error_count   = 0;
  int       quiet_cycles  = 0;
  int       send_idle_pct = 19;
  int       recv_idle_pct = 47;

  multi_well_euler_filter #(.MAX_WELLS(MAX_WELLS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One Euler step: find the well that holds the state, take its gradient,
  // advance the state and report the well and any clipping.
  function automatic mwe_out_t euler_step(mwe_in_t item);
    longint   x, xb, nw, c, d, sq, cube, grad, sum, raw, nx, i;
    logic     hit, found, sat;
    mwe_out_t res;
    x    = state_sh;
    xb   = longint'(spacing_sh);
    nw   = longint'(wells_sh);
    grad = 0;
    found = 1'b0;
    sat   = 1'b0;
    res.well_index = '0;
    if (nw < 1) nw = 1;
    if (nw > MAX_WELLS) nw = MAX_WELLS;
    for (i = 0; i < nw && !found; i++) begin
      c   = (2 * i - (nw - 1)) * xb;
      // edge wells reach out to infinity, central wells span +-Xb
      hit = (i == 0 && x <= c + xb) || (i == nw - 1 && x >= c - xb) ||
            (x >= c - xb && x <= c + xb);
      if (hit) begin
        d    = x - c;
        raw  = (d * d) >>> FRAC_BITS;
        sq   = clamp(raw, -SQ_LIMIT, SQ_LIMIT);
        if (sq != raw) sat = 1'b1;
        raw  = (sq * d) >>> FRAC_BITS;
        cube = clamp(raw, -CUBE_LIMIT_TB, CUBE_LIMIT_TB);
        if (cube != raw) sat = 1'b1;
        raw  = ((cube * longint'(inv_sh)) >>> FRAC_BITS) - d;
        grad = clamp(raw, STATE_MIN, STATE_MAX);
        if (grad != raw) sat = 1'b1;
        res.well_index = i[IDX_W-1:0];
        found = 1'b1;
      end
    end
    sum = longint'($signed(item.signal_sample)) + longint'($signed(item.noise_sample)) - grad;
    raw = x + ((sum * longint'(gain_sh)) >>> FRAC_BITS);
    nx  = clamp(raw, STATE_MIN, STATE_MAX);
    if (nx != raw) sat = 1'b1;
    state_sh = nx;
    res.filtered_state = nx[SAMPLE_WIDTH-1:0];
    res.saturated      = sat;
    return res;
  endfunction

  task automatic check_result(mwe_out_t got);
    mwe_out_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with nothing expected: state %0d well %0d sat %0b",
               $time, got.filtered_state, got.well_index, got.saturated);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.filtered_state !== want.filtered_state) begin
        $display("%0t: filtered_state expected %0d, got %0d",
                 $time, want.filtered_state, got.filtered_state);
        error_count++;
      end
      if (got.well_index !== want.well_index) begin
        $display("%0t: well_index expected %0d, got %0d",
                 $time, want.well_index, got.well_index);
        error_count++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %0b, got %0b",
                 $time, want.saturated, got.saturated);
        error_count++;
      end
    end
  endtask

  // input driver: predict on accept, then present the next item or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(euler_step(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT - 1) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // start at a rising edge; return at a rising edge with the bus idle
  task automatic write_reg(logic [1:0] index, logic [DATA_W-1:0] value);
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (index)
      REG_STEP_GAIN:    gain_sh    = value[GAIN_W-1:0];
      REG_WELL_COUNT:   wells_sh   = value[WCNT_W-1:0];
      REG_HALF_SPACING: spacing_sh = value[XB_W-1:0];
      REG_INV_SPACING:  inv_sh     = value[XB_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(logic [GAIN_W-1:0] gain, logic [WCNT_W-1:0] wells,
                           logic [XB_W-1:0] spacing, logic [XB_W-1:0] inv);
    write_reg(REG_STEP_GAIN, DATA_W'(gain));
    write_reg(REG_WELL_COUNT, DATA_W'(wells));
    write_reg(REG_HALF_SPACING, DATA_W'(spacing));
    write_reg(REG_INV_SPACING, DATA_W'(inv));
  endtask

  task automatic random_config();
    logic [GAIN_W-1:0] gain;
    logic [WCNT_W-1:0] wells;
    logic [XB_W-1:0]   spacing, inv;
    longint            ideal;
    case ($urandom_range(0, 5))
      0:       gain = '0;
      1:       gain = '1;
      default: gain = GAIN_W'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 9))
      0:       wells = '0;
      1:       wells = WCNT_W'($urandom_range(MAX_WELLS + 1, 31));
      2:       wells = WCNT_W'(1);
      3:       wells = WCNT_W'(MAX_WELLS);
      default: wells = WCNT_W'($urandom_range(2, MAX_WELLS));
    endcase
    case ($urandom_range(0, 9))
      0:       spacing = '0;
      1:       spacing = '1;
      2:       spacing = XB_W'(1);
      default: spacing = XB_W'($urandom_range(1 << 14, 1 << 21));
    endcase
    // matching 1/Xb^2 keeps the wells shaped so the state settles into them
    ideal = (spacing == 0) ? 1 :
            (64'sd1 <<< 48) / (longint'(spacing) * longint'(spacing));
    ideal = clamp(ideal, 1, XB_FULL);
    case ($urandom_range(0, 9))
      0:       inv = '0;
      1:       inv = '1;
      2:       inv = XB_W'(1);
      default: inv = ideal[XB_W-1:0];
    endcase
    configure(gain, wells, spacing, inv);
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return r[0] ? '0 : '1;
      3, 4, 5: return r[SAMPLE_WIDTH-1:0];
      default: return {{(SAMPLE_WIDTH-21){r[20]}}, r[20:0]};
    endcase
  endfunction

  task automatic queue_item(logic signed [SAMPLE_WIDTH-1:0] sig,
                            logic signed [SAMPLE_WIDTH-1:0] noise);
    mwe_in_t item;
    item.signal_sample = sig;
    item.noise_sample  = noise;
    pending_items.push_back(item);
  endtask

  // sample between edges so the driver's updates have settled, then realign
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    @(posedge clk_i);
  endtask

  initial begin
    int phase;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults after reset
    queue_item('0, '0);
    queue_item(SAMPLE_MAX, SAMPLE_MAX);
    queue_item(SAMPLE_MIN, SAMPLE_MIN);
    queue_item(SAMPLE_MAX, SAMPLE_MIN);
    queue_item(SAMPLE_MIN, SAMPLE_MAX);
    queue_item(SAMPLE_WIDTH'(-1), SAMPLE_WIDTH'(1));
    wait_drained();

    // sixteen wells over the full range, full gain: drive state to both rails
    configure('1, WCNT_W'(MAX_WELLS), 23'd524288, 23'd1024);
    repeat (4) queue_item(SAMPLE_MAX, SAMPLE_MAX);
    repeat (5) queue_item(SAMPLE_MIN, SAMPLE_MIN);
    wait_drained();

    // zero well count runs as one well; zero spacing puts every centre at 0
    configure('1, '0, '0, '1);
    queue_item(SAMPLE_MAX, '0);
    queue_item(SAMPLE_MIN, '0);
    queue_item('0, '0);
    wait_drained();

    // well count above the maximum, zero gain holds the state
    configure('0, 5'd31, 23'd1, 23'd1);
    queue_item(SAMPLE_MAX, SAMPLE_MAX);
    queue_item('0, SAMPLE_MIN);
    wait_drained();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 19;
      end else if (phase == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config();
      repeat (ITEMS_PER_PHASE) queue_item(rand_sample(), rand_sample());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
